FILE: hw/rtl/tlc_pkg.sv
// Shared types and constants for the two-point linear calibration block.
package tlc_pkg;

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned HALF_W      = 16;
    localparam int unsigned STORE_DEPTH = 6;
    localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_POINT_ZERO = 2'd1;
    localparam logic [1:0] STATUS_EQUAL_ADC  = 2'd2;
    localparam logic [1:0] STATUS_BAD_INDEX  = 2'd3;

    localparam logic [1:0] KIND_MAX     = 2'd2;
    localparam logic [1:0] POINT_FIRST  = 2'd1;
    localparam logic [1:0] POINT_SECOND = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        point_index;
        logic [HALF_W-1:0] reference_value;
        logic [HALF_W-1:0] adc_reading;
    } tlc_in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] gain;
        logic [DATA_W-1:0] offset;
    } tlc_out_t;

endpackage

FILE: hw/rtl/tlc_stream_if.sv
// Valid/ready stream interface carrying one payload beat per handshake.
interface tlc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/tlc_div.sv
// Restoring divider that produces one quotient bit per cycle.
module tlc_div
    import tlc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] quotient
);

    localparam int unsigned CNT_W = $clog2(DATA_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] dsr_reg;

    logic [DATA_W:0]   trial;
    logic              fits;
    logic [DATA_W-1:0] rem_next;

    assign trial    = {rem_reg, quo_reg[DATA_W-1]};
    assign fits     = trial >= {1'b0, dsr_reg};
    assign rem_next = fits ? DATA_W'(trial - {1'b0, dsr_reg}) : trial[DATA_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DATA_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hw/rtl/two_point_linear_calibration.sv
// Two-point linear calibration: stores points per channel and solves gain and offset.
// A bad index goes straight to the result; a zero point or equal readings finish after
// the check. Otherwise one pass of the bit-serial divider and of the shift-add multiplier
// over the 16 reading bits solves the gain, and a second pass of each raises the gain
// when the first product falls short of set point 2.
// Throughput: one beat at a time; a new beat is taken while a result waits in the
// output register. Reset clears the control state and the point store valid bits.
module two_point_linear_calibration
    import tlc_pkg::*;
#(
    parameter int unsigned FRACTION_BITS = 13
)
(
    input  logic         clk,
    input  logic         rst_n,
    tlc_stream_if.sink   point,
    tlc_stream_if.source result
);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_STORE  = 11'b000_0000_0010,
        ST_LOAD   = 11'b000_0000_0100,
        ST_CHECK  = 11'b000_0000_1000,
        ST_DIV1   = 11'b000_0001_0000,
        ST_MUL1   = 11'b000_0010_0000,
        ST_CMP    = 11'b000_0100_0000,
        ST_DIV2   = 11'b000_1000_0000,
        ST_MUL2   = 11'b001_0000_0000,
        ST_OFFS   = 11'b010_0000_0000,
        ST_FINISH = 11'b100_0000_0000
    } state_t;

    localparam int unsigned MCNT_W = $clog2(HALF_W);
    localparam logic [MCNT_W-1:0] MCNT_LAST = MCNT_W'(HALF_W - 1);

    state_t state_reg;
    state_t state_next;

    logic [DATA_W-1:0] mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] valid_reg;

    tlc_in_t  in_reg;
    tlc_out_t out_reg;
    logic     out_valid_reg;

    logic [DATA_W-1:0] rd0_reg;
    logic [DATA_W-1:0] rd1_reg;
    logic              v0_reg;
    logic              v1_reg;

    logic [HALF_W-1:0] s1_reg;
    logic [HALF_W-1:0] r1_reg;
    logic [1:0]        status_reg;
    logic [DATA_W-1:0] g_reg;
    logic [DATA_W-1:0] off_reg;

    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] mshift_reg;
    logic [HALF_W-1:0] mbits_reg;
    logic [MCNT_W-1:0] mcnt_reg;

    logic              in_fire;
    logic              in_bad;
    logic              out_load;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd0_addr;
    logic [ADDR_W-1:0] rd1_addr;

    logic [DATA_W-1:0] e0;
    logic [DATA_W-1:0] e1;
    logic [HALF_W-1:0] s0;
    logic [HALF_W-1:0] r0;
    logic [HALF_W-1:0] s1;
    logic [HALF_W-1:0] r1;
    logic              any_zero;
    logic              same_adc;
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;
    logic [DATA_W-1:0] s1_ext;
    logic [DATA_W-1:0] r1_ext;
    logic [DATA_W-1:0] target;
    logic              below;
    logic [DATA_W-1:0] raise_num;
    logic [DATA_W-1:0] acc_step;
    logic [DATA_W-1:0] g_raised;

    logic              div_start;
    logic [DATA_W-1:0] div_dividend;
    logic [DATA_W-1:0] div_divisor;
    logic              div_done;
    logic [DATA_W-1:0] div_quotient;

    tlc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign point.ready   = (state_reg == ST_IDLE);
    assign in_fire       = point.valid && point.ready;
    assign in_bad        = (point.payload.kind > KIND_MAX)
                        || ((point.payload.point_index != POINT_FIRST)
                         && (point.payload.point_index != POINT_SECOND));
    assign out_load      = (state_reg == ST_FINISH) && (!out_valid_reg || result.ready);
    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    assign wr_addr  = {in_reg.kind, in_reg.point_index == POINT_SECOND};
    assign rd0_addr = {in_reg.kind, 1'b0};
    assign rd1_addr = {in_reg.kind, 1'b1};

    assign e0       = v0_reg ? rd0_reg : '0;
    assign e1       = v1_reg ? rd1_reg : '0;
    assign s0       = e0[DATA_W-1:HALF_W];
    assign r0       = e0[HALF_W-1:0];
    assign s1       = e1[DATA_W-1:HALF_W];
    assign r1       = e1[HALF_W-1:0];
    assign any_zero = (s0 == '0) || (r0 == '0) || (s1 == '0) || (r1 == '0);
    assign same_adc = (r0 == r1);
    assign num      = DATA_W'(({{HALF_W{1'b0}}, s1} - {{HALF_W{1'b0}}, s0}) << FRACTION_BITS);
    assign den      = {{HALF_W{1'b0}}, r1} - {{HALF_W{1'b0}}, r0};

    assign s1_ext    = {{HALF_W{1'b0}}, s1_reg};
    assign r1_ext    = {{HALF_W{1'b0}}, r1_reg};
    assign target    = DATA_W'(s1_ext << FRACTION_BITS);
    assign below     = acc_reg < target;
    assign raise_num = target - acc_reg + r1_ext - DATA_W'(1);
    assign acc_step  = mbits_reg[0] ? acc_reg + mshift_reg : acc_reg;
    assign g_raised  = g_reg + div_quotient;

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = num;
        div_divisor  = den;
        if (state_reg == ST_CHECK)
        begin
            div_start = !any_zero && !same_adc;
        end
        else if (state_reg == ST_CMP)
        begin
            div_start    = below;
            div_dividend = raise_num;
            div_divisor  = r1_ext;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = in_bad ? ST_FINISH : ST_STORE;
                end
            end
            ST_STORE:  state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_CHECK;
            ST_CHECK:  state_next = (any_zero || same_adc) ? ST_FINISH : ST_DIV1;
            ST_DIV1:
            begin
                if (div_done)
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                if (mcnt_reg == MCNT_LAST)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:    state_next = below ? ST_DIV2 : ST_OFFS;
            ST_DIV2:
            begin
                if (div_done)
                begin
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                if (mcnt_reg == MCNT_LAST)
                begin
                    state_next = ST_OFFS;
                end
            end
            ST_OFFS:   state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_STORE)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_STORE)
        begin
            mem[wr_addr] <= {in_reg.reference_value, in_reg.adc_reading};
        end
        if (state_reg == ST_LOAD)
        begin
            rd0_reg <= mem[rd0_addr];
            rd1_reg <= mem[rd1_addr];
            v0_reg  <= valid_reg[rd0_addr];
            v1_reg  <= valid_reg[rd1_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_reg     <= point.payload;
            status_reg <= STATUS_BAD_INDEX;
            g_reg      <= '0;
            off_reg    <= '0;
        end
        if (state_reg == ST_CHECK)
        begin
            s1_reg <= s1;
            r1_reg <= r1;
            if (any_zero)
            begin
                status_reg <= STATUS_POINT_ZERO;
            end
            else if (same_adc)
            begin
                status_reg <= STATUS_EQUAL_ADC;
            end
        end
        if ((state_reg == ST_DIV1) && div_done)
        begin
            g_reg      <= div_quotient;
            acc_reg    <= '0;
            mshift_reg <= div_quotient;
            mbits_reg  <= r1_reg;
            mcnt_reg   <= '0;
        end
        if ((state_reg == ST_DIV2) && div_done)
        begin
            g_reg      <= g_raised;
            acc_reg    <= '0;
            mshift_reg <= g_raised;
            mbits_reg  <= r1_reg;
            mcnt_reg   <= '0;
        end
        if ((state_reg == ST_MUL1) || (state_reg == ST_MUL2))
        begin
            acc_reg    <= acc_step;
            mshift_reg <= {mshift_reg[DATA_W-2:0], 1'b0};
            mbits_reg  <= {1'b0, mbits_reg[HALF_W-1:1]};
            mcnt_reg   <= mcnt_reg + MCNT_W'(1);
        end
        if (state_reg == ST_OFFS)
        begin
            status_reg <= STATUS_OK;
            off_reg    <= (acc_reg >> FRACTION_BITS) - s1_ext;
        end
        if (out_load)
        begin
            out_reg.status <= status_reg;
            out_reg.gain   <= g_reg;
            out_reg.offset <= off_reg;
        end
    end

endmodule

FILE: sim/tb.sv
// Testbench for two_point_linear_calibration: directed and random points against a predictor.
`timescale 1ns / 1ps

module tb
    import tlc_pkg::*;
();

    localparam int unsigned FRAC_BITS   = 13;
    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned DRAIN_WAIT  = 120;
    localparam int unsigned PHASE_ITEMS = 530;

    class calibration_checker;
        logic [DATA_W-1:0] cal_points [STORE_DEPTH];
        tlc_out_t          expected_fits [$];
        int                mismatches;

        function new();
            foreach (cal_points[i])
            begin
                cal_points[i] = '0;
            end
            mismatches = 0;
        endfunction

        function tlc_out_t fit_line(logic [DATA_W-1:0] lo, logic [DATA_W-1:0] hi);
            tlc_out_t    fit;
            bit [31:0]   s0, r0, s1, r1, num, den, g, p, target, k;
            fit = '0;
            s0 = {16'd0, lo[31:16]};
            r0 = {16'd0, lo[15:0]};
            s1 = {16'd0, hi[31:16]};
            r1 = {16'd0, hi[15:0]};
            if (s0 == 0 || r0 == 0 || s1 == 0 || r1 == 0)
            begin
                fit.status = STATUS_POINT_ZERO;
                return fit;
            end
            den = r1 - r0;
            if (den == 0)
            begin
                fit.status = STATUS_EQUAL_ADC;
                return fit;
            end
            num = (s1 - s0) << FRAC_BITS;
            g = num / den;
            p = r1 * g;
            target = s1 << FRAC_BITS;
            if (p < target)
            begin
                k = (target - p + r1 - 32'd1) / r1;
                g = g + k;
                p = p + k * r1;
            end
            fit.status = STATUS_OK;
            fit.gain   = g;
            fit.offset = (p >> FRAC_BITS) - s1;
            return fit;
        endfunction

        function void note_point(tlc_in_t item);
            tlc_out_t fit;
            int       base;
            if (item.kind > KIND_MAX ||
                (item.point_index != POINT_FIRST && item.point_index != POINT_SECOND))
            begin
                fit = '0;
                fit.status = STATUS_BAD_INDEX;
            end
            else
            begin
                base = int'(item.kind) * 2;
                cal_points[base + int'(item.point_index) - 1] =
                    {item.reference_value, item.adc_reading};
                fit = fit_line(cal_points[base], cal_points[base + 1]);
            end
            expected_fits.push_back(fit);
        endfunction

        task report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
            $display("mismatch %s: got %h want %h", what, got, want);
            mismatches++;
        endtask

        task check_result(tlc_out_t got);
            tlc_out_t want;
            if (expected_fits.size() == 0)
            begin
                report("unexpected beat", {30'd0, got.status}, '0);
                return;
            end
            want = expected_fits.pop_front();
            if (got.status !== want.status)
                report("status", {30'd0, got.status}, {30'd0, want.status});
            if (got.gain !== want.gain)
                report("gain", got.gain, want.gain);
            if (got.offset !== want.offset)
                report("offset", got.offset, want.offset);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   quiet_cycles;

    calibration_checker checker_h;

    tlc_stream_if #(.payload_t(tlc_in_t))  point_if ();
    tlc_stream_if #(.payload_t(tlc_out_t)) result_if ();

    two_point_linear_calibration #(.FRACTION_BITS(FRAC_BITS)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point_if),
        .result (result_if)
    );

    initial
    begin
        rst_n = 1'b0;
        point_if.valid = 1'b0;
        point_if.payload = '0;
        result_if.ready = 1'b0;
        src_idle_pct = 28;
        snk_idle_pct = 79;
        quiet_cycles = 0;
        checker_h = new();
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        result_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (point_if.valid && point_if.ready)
                checker_h.note_point(point_if.payload);
            if (result_if.valid && result_if.ready)
                checker_h.check_result(result_if.payload);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((point_if.valid && point_if.ready) || (result_if.valid && result_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAIL two_point_linear_calibration");
                $finish;
            end
        end
    end

    task automatic send_point(input logic [1:0] kind, input logic [1:0] pt,
                              input logic [15:0] ref_val, input logic [15:0] adc_val);
        tlc_in_t item;
        item.kind = kind;
        item.point_index = pt;
        item.reference_value = ref_val;
        item.adc_reading = adc_val;
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            point_if.valid <= 1'b0;
            @(negedge clk);
        end
        point_if.valid <= 1'b1;
        point_if.payload <= item;
        do
            @(posedge clk);
        while (!point_if.ready);
    endtask

    function automatic logic [15:0] pick_value(bit allow_zero);
        int sel;
        sel = $urandom_range(99);
        if (allow_zero && sel < 8)
            return 16'd0;
        else if (sel < 16)
            return 16'hFFFF;
        else if (sel < 26)
            return 16'($urandom_range(4, 1));
        else if (sel < 40)
            return 16'($urandom_range(255, 1));
        else
            return 16'($urandom_range(65535, 1));
    endfunction

    task automatic random_points(input int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 85)
                send_point(2'($urandom_range(2)), 2'($urandom_range(2, 1)),
                           pick_value(1'b0), pick_value(1'b0));
            else
                send_point(2'($urandom_range(3)), 2'($urandom_range(3)),
                           pick_value(1'b1), pick_value(1'b1));
        end
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        send_point(2'd0, 2'd0, 16'd100, 16'd200);
        send_point(2'd1, 2'd3, 16'hFFFF, 16'hFFFF);
        send_point(2'd3, 2'd1, 16'd5, 16'd5);
        send_point(2'd3, 2'd2, 16'hFFFF, 16'hFFFF);
        send_point(2'd0, 2'd1, 16'd100, 16'd200);
        send_point(2'd0, 2'd2, 16'd1000, 16'd2000);
        send_point(2'd0, 2'd2, 16'd500, 16'd200);
        send_point(2'd0, 2'd1, 16'd0, 16'd300);
        send_point(2'd0, 2'd1, 16'd1, 16'd1);
        send_point(2'd0, 2'd2, 16'hFFFF, 16'hFFFF);
        send_point(2'd1, 2'd1, 16'hFFFF, 16'hFFFF);
        send_point(2'd1, 2'd2, 16'd1, 16'd1);
        send_point(2'd1, 2'd2, 16'hFFFF, 16'd1);
        send_point(2'd1, 2'd1, 16'd1, 16'd2);
        send_point(2'd2, 2'd2, 16'd40000, 16'd30000);
        send_point(2'd2, 2'd1, 16'd10000, 16'd0);
        send_point(2'd2, 2'd1, 16'd10000, 16'd5000);
        send_point(2'd2, 2'd1, 16'd0, 16'hFFFF);
        send_point(2'd2, 2'd1, 16'd3, 16'd7);
        send_point(2'd2, 2'd2, 16'd3, 16'd7);
        send_point(2'd2, 2'd2, 16'd12345, 16'd54321);
        random_points(PHASE_ITEMS);

        src_idle_pct = 79;
        snk_idle_pct = 28;
        random_points(PHASE_ITEMS);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        random_points(PHASE_ITEMS);

        @(negedge clk);
        point_if.valid <= 1'b0;
        while (checker_h.expected_fits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (checker_h.mismatches == 0)
            $display("PASS two_point_linear_calibration");
        else
            $display("FAIL two_point_linear_calibration");
        $finish;
    end
endmodule
